// ===== design/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, status codes and types of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS      = 24;
    localparam int BLOCK_BYTES     = 64;
    localparam int MAX_FILE_BLOCKS = 4;

    // Result slots reported per allocation.
    localparam int SLOTS    = 4;
    localparam int IDX_W    = $clog2(NUM_BLOCKS);
    localparam int NEED_W   = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 3;
    localparam int SLOT_W   = 5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_find_res;

endpackage
`default_nettype wire

// ===== design/bitmap_block_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit allocator of fixed-size blocks over a used-block bitmap.
// ----------------------------------------------------------------------------
// A request word carries a file size in bytes on i_file_size, moved by
// i_in_valid / o_in_ready. The size is rounded up to whole blocks. One
// result word per request leaves on o_out_valid / i_out_ready with a
// status, the granted block count and up to four block indices (zero in
// unused slots and on any failure).
// The sequencer takes the word, sizes it, visits the shared free-block
// search once per granted block and then loads the result register; a
// zero size or a request that is too large goes from sizing straight to
// the load step, as does a search that finds no free block. One request
// is in work at a time; o_in_ready is high only while the sequencer is
// idle.
// A failed request leaves the bitmap unchanged.
// Reset clears the bitmap (every block free) and drops o_out_valid.
// If the receiver stalls, the result word holds; the next request is
// still taken and worked, and waits in the load step for the register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [bba_pkg::SIZE_W-1:0]   i_file_size,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [bba_pkg::STATUS_W-1:0]      o_status,
    output logic [bba_pkg::COUNT_W-1:0]       o_block_count,
    output logic [bba_pkg::SLOT_W-1:0]        o_first_block,
    output logic [bba_pkg::SLOT_W-1:0]        o_second_block,
    output logic [bba_pkg::SLOT_W-1:0]        o_third_block,
    output logic [bba_pkg::SLOT_W-1:0]        o_fourth_block
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIND, S_EMIT} t_state;

    t_state                             r_state;
    logic [bba_pkg::NUM_BLOCKS-1:0]     r_used_map;
    logic [bba_pkg::NUM_BLOCKS-1:0]     r_work;
    logic [bba_pkg::SIZE_W-1:0]         r_size;
    logic [bba_pkg::NEED_W-1:0]         r_need;
    logic [bba_pkg::NEED_W-1:0]         r_count;
    logic [bba_pkg::STATUS_W-1:0]       r_status;
    logic [bba_pkg::SLOT_W-1:0]         r_pick [bba_pkg::SLOTS];
    logic                               r_out_valid;
    logic [bba_pkg::SLOT_W-1:0]         r_out_slot [bba_pkg::SLOTS];
    logic [bba_pkg::STATUS_W-1:0]       r_out_status;
    logic [bba_pkg::COUNT_W-1:0]        r_out_count;

    logic [bba_pkg::NEED_W-1:0]         need_calc;
    logic                               too_large;
    logic [31:0]                        pick_ext;
    bba_pkg::t_find_res                 find_res;

    bba_find_free u_find (
        .i_mask (r_work),
        .o_res  (find_res)
    );

    // Rounding up by threshold compares against constant multiples of the
    // block size; valid whenever the request is not too large.
    always_comb begin
        too_large = 32'(r_size) > bba_pkg::MAX_FILE_BLOCKS * bba_pkg::BLOCK_BYTES;
        need_calc = '0;
        for (int k = 0; k < bba_pkg::MAX_FILE_BLOCKS; k++) begin
            if (32'(r_size) > k * bba_pkg::BLOCK_BYTES) begin
                need_calc = need_calc + 1'b1;
            end
        end
    end

    assign pick_ext = 32'(find_res.index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used_map  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The load step owns the valid flag while it is active.
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_size  <= i_file_size;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_work  <= r_used_map;
                    r_count <= '0;
                    r_need  <= need_calc;
                    if (too_large) begin
                        r_status <= bba_pkg::ST_TOO_LARGE;
                        r_state  <= S_EMIT;
                    end else if (need_calc == '0) begin
                        r_status <= bba_pkg::ST_OK;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (!find_res.found) begin
                        r_status <= bba_pkg::ST_NO_SPACE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_work[find_res.index] <= 1'b1;
                        for (int s = 0; s < bba_pkg::SLOTS; s++) begin
                            if (int'(r_count) == s) begin
                                r_pick[s] <= pick_ext[bba_pkg::SLOT_W-1:0];
                            end
                        end
                        r_count <= r_count + 1'b1;
                        if (r_count + 1'b1 == r_need) begin
                            r_status <= bba_pkg::ST_OK;
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        if (r_status == bba_pkg::ST_OK) begin
                            // Success commits the working map with the new grants.
                            r_used_map  <= r_work;
                            r_out_count <= bba_pkg::COUNT_W'(r_need);
                        end else begin
                            r_out_count <= '0;
                        end
                        for (int s = 0; s < bba_pkg::SLOTS; s++) begin
                            if (r_status == bba_pkg::ST_OK && s < int'(r_need)) begin
                                r_out_slot[s] <= r_pick[s];
                            end else begin
                                r_out_slot[s] <= '0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_block_count  = r_out_count;
    assign o_first_block  = r_out_slot[0];
    assign o_second_block = r_out_slot[1];
    assign o_third_block  = r_out_slot[2];
    assign o_fourth_block = r_out_slot[3];

    // The bitmap changes only as a successful result word is loaded.
    a_map_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_used_map) |-> (r_out_valid && o_status == bba_pkg::ST_OK))
        else $error("block map changed without a successful grant");

    // A failed request reports no blocks.
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_status != bba_pkg::ST_OK) |->
        (o_block_count == '0 && o_first_block == '0 && o_fourth_block == '0))
        else $error("failed request reports blocks");

    // The search never runs past the number of blocks needed.
    a_find_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (r_count < r_need))
        else $error("search ran past the needed block count");

endmodule
`default_nettype wire

// ===== design/bba_find_free.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_find_free
// Shared search unit: returns the lowest-numbered clear bit of a block map.
// ----------------------------------------------------------------------------
module bba_find_free (
    input  wire logic [bba_pkg::NUM_BLOCKS-1:0] i_mask,
    output bba_pkg::t_find_res                  o_res
);

    always_comb begin
        o_res.found = 1'b0;
        o_res.index = '0;
        // Scanning downward lets the lowest free block win.
        for (int b = bba_pkg::NUM_BLOCKS - 1; b >= 0; b--) begin
            if (!i_mask[b]) begin
                o_res.found = 1'b1;
                o_res.index = bba_pkg::IDX_W'(b);
            end
        end
    end

endmodule
`default_nettype wire
